// File: src/hlt_pkg.sv
// shared types and constants for the held latch table
`timescale 1ns / 1ps

package hlt_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 32;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 32;
  localparam int REF_W  = 32;
  localparam int MODE_W = 2;
  localparam int ST_W   = 3;

  localparam logic [MODE_W-1:0] MODE_NONE = '0;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_FIND   = 2'd2,
    OP_UPDATE = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // command broadcast to every cell
  typedef struct packed {
    logic              push_en;
    logic              pop_en;
    logic              upd_en;
    logic [KEY_W-1:0]  key;
    logic [REF_W-1:0]  obj_ref;
    logic [MODE_W-1:0] new_mode;
    logic [MODE_W-1:0] exp_mode;
  } hlt_cmd_t;

  // stored entry handed to the next lower cell on removal
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [REF_W-1:0]  obj_ref;
    logic [MODE_W-1:0] mode;
  } hlt_entry_t;

  // search result travelling from newest toward oldest cell
  typedef struct packed {
    logic              hit;
    logic [REF_W-1:0]  f_ref;
    logic [MODE_W-1:0] f_mode;
  } hlt_find_t;

endpackage

// File: src/hlt_in_if.sv
// request channel of the held latch table
`timescale 1ns / 1ps

interface hlt_in_if;
  import hlt_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [KEY_W-1:0]  key;
  logic              key_valid;
  logic [REF_W-1:0]  object_ref;
  logic [MODE_W-1:0] new_mode;
  logic [MODE_W-1:0] expected_mode;

  modport source (
    output valid, opcode, key, key_valid, object_ref, new_mode, expected_mode,
    input  ready
  );

  modport sink (
    input  valid, opcode, key, key_valid, object_ref, new_mode, expected_mode,
    output ready
  );
endinterface

// File: src/hlt_out_if.sv
// result channel of the held latch table
`timescale 1ns / 1ps

interface hlt_out_if #(
  parameter int CNT_W = $clog2(hlt_pkg::DEPTH_DEF + 1)
);
  import hlt_pkg::*;

  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic              hit;
  logic [REF_W-1:0]  found_ref;
  logic [MODE_W-1:0] found_mode;
  logic [CNT_W-1:0]  held_count;

  modport source (
    output valid, status, hit, found_ref, found_mode, held_count,
    input  ready
  );

  modport sink (
    input  valid, status, hit, found_ref, found_mode, held_count,
    output ready
  );
endinterface

// File: src/held_latch_table_core.sv
// top level of the held latch table: command register, cell row, result register
`timescale 1ns / 1ps

// Held latch table. Requests arrive on in_i (push, pop, find, update mode) and
// each produces exactly one result on out_o, in request order.
// The table is a row of DEPTH cells, oldest entry in cell 0. All cells compare
// the key at once; the newest match is picked by a ripple through the row, and
// a pop moves every cell above the removed one down by one in the same cycle.
// Timing: a request is registered in the command register when it is accepted
// and then executed over the cell row, where the result lands in the output
// register. A new request is accepted only once the previous one has executed.
// Result valid rises at the edge that executes the request.
// A result waiting in the output register does not block the next request
// from being accepted; if the receiver stalls, execution of that next request
// holds (the table is not touched) until the output register frees up.
// Reset empties the table (held count zero), clears the busy flag and the
// result valid; entry contents are left as is and are never read while unoccupied.

module held_latch_table_core #(
  parameter int DEPTH    = hlt_pkg::DEPTH_DEF,
  parameter int KEY_BITS = hlt_pkg::KEY_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  hlt_in_if.sink   in_i,
  hlt_out_if.source out_o
);
  import hlt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  // command register
  logic              busy_q;
  op_e               op_q;
  logic [KEY_W-1:0]  key_q;
  logic              kvld_q;
  logic [REF_W-1:0]  ref_q;
  logic [MODE_W-1:0] nmode_q;
  logic [MODE_W-1:0] emode_q;

  logic [CNT_W-1:0]  count_q, count_d;

  // output register
  logic              ovld_q;
  status_e           status_q, status_d;
  logic              hit_q, hit_d;
  logic [REF_W-1:0]  fref_q, fref_d;
  logic [MODE_W-1:0] fmode_q, fmode_d;
  logic [CNT_W-1:0]  held_q;

  logic     exec;
  logic     full;
  logic     push_ok;
  logic     srch_ok;
  hlt_cmd_t cmd;

  hlt_entry_t ent [DEPTH+1];
  hlt_find_t  dn  [DEPTH+1];
  logic       up  [DEPTH+1];

  assign in_i.ready = !busy_q;
  assign exec       = busy_q && (!ovld_q || out_o.ready);
  assign full       = (count_q == CNT_W'(DEPTH));
  assign push_ok    = (op_q == OP_PUSH) && kvld_q && (nmode_q != MODE_NONE) && !full;
  assign srch_ok    = (op_q != OP_PUSH) && kvld_q
                      && !((op_q == OP_UPDATE) && (nmode_q == MODE_NONE));

  assign cmd.push_en  = exec && push_ok;
  assign cmd.pop_en   = exec && srch_ok && (op_q == OP_POP);
  assign cmd.upd_en   = exec && srch_ok && (op_q == OP_UPDATE);
  assign cmd.key      = key_q;
  assign cmd.obj_ref  = ref_q;
  assign cmd.new_mode = nmode_q;
  assign cmd.exp_mode = emode_q;

  // nothing sits above the newest cell
  assign ent[DEPTH] = '0;
  assign dn[DEPTH]  = '0;
  assign up[0]      = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    hlt_cell #(
      .KW (KW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .occ_i   (CNT_W'(i) < count_q),
      .tail_i  (CNT_W'(i) == count_q),
      .above_i (ent[i+1]),
      .entry_o (ent[i]),
      .dn_i    (dn[i+1]),
      .dn_o    (dn[i]),
      .up_i    (up[i]),
      .up_o    (up[i+1])
    );
  end

  always_comb begin
    status_d = ST_OK;
    hit_d    = 1'b0;
    fref_d   = '0;
    fmode_d  = '0;
    count_d  = count_q;
    if (op_q == OP_PUSH) begin
      if (!kvld_q || (nmode_q == MODE_NONE)) begin
        status_d = ST_INVALID;
      end else if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (!srch_ok) begin
      status_d = ST_INVALID;
    end else if (!dn[0].hit) begin
      status_d = ST_NOT_FOUND;
    end else begin
      hit_d = 1'b1;
      case (op_q)
        OP_UPDATE: begin
          if (dn[0].f_mode != emode_q) status_d = ST_MISMATCH;
        end
        OP_POP: begin
          fref_d  = dn[0].f_ref;
          fmode_d = dn[0].f_mode;
          count_d = count_q - 1'b1;
        end
        OP_FIND: begin
          fref_d  = dn[0].f_ref;
          fmode_d = dn[0].f_mode;
        end
        default: begin
          status_d = ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      ovld_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        busy_q <= 1'b1;
      end else if (exec) begin
        busy_q <= 1'b0;
      end
      if (exec) begin
        ovld_q  <= 1'b1;
        count_q <= count_d;
      end else if (out_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q    <= op_e'(in_i.opcode);
      key_q   <= in_i.key;
      kvld_q  <= in_i.key_valid;
      ref_q   <= in_i.object_ref;
      nmode_q <= in_i.new_mode;
      emode_q <= in_i.expected_mode;
    end
    if (exec) begin
      status_q <= status_d;
      hit_q    <= hit_d;
      fref_q   <= fref_d;
      fmode_q  <= fmode_d;
      held_q   <= count_d;
    end
  end

  assign out_o.valid      = ovld_q;
  assign out_o.status     = status_q;
  assign out_o.hit        = hit_q;
  assign out_o.found_ref  = fref_q;
  assign out_o.found_mode = fmode_q;
  assign out_o.held_count = held_q;

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("held count above depth");

  // the upward and downward chains must agree on whether some cell matched
  a_chain_agree : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (up[DEPTH] == dn[0].hit))
    else $error("match chains disagree");

  a_pop_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.pop_en && dn[0].hit) |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop did not remove an entry");

  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(exec))
    else $error("result appeared without execution");

  a_full_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && full) |-> !cmd.push_en)
    else $error("push into full table");

endmodule

// File: src/hlt_cell.sv
// one table slot: stores an entry, compares its key, shifts down on removal
`timescale 1ns / 1ps

module hlt_cell #(
  parameter int KW = hlt_pkg::KEY_BITS_DEF
) (
  input  logic                clk_i,
  input  hlt_pkg::hlt_cmd_t   cmd_i,
  input  logic                occ_i,
  input  logic                tail_i,
  input  hlt_pkg::hlt_entry_t above_i,
  output hlt_pkg::hlt_entry_t entry_o,
  input  hlt_pkg::hlt_find_t  dn_i,
  output hlt_pkg::hlt_find_t  dn_o,
  input  logic                up_i,
  output logic                up_o
);
  import hlt_pkg::*;

  logic [KW-1:0]     key_q;
  logic [REF_W-1:0]  ref_q;
  logic [MODE_W-1:0] mode_q;

  logic match;
  logic sel;
  logic shift;

  assign match = occ_i && (key_q == cmd_i.key[KW-1:0]);
  // newest match wins: nothing matched further up
  assign sel   = match && !dn_i.hit;
  // removal: this cell and everything above the chosen one moves down
  assign shift = cmd_i.pop_en && (sel || up_i);

  assign dn_o.hit    = dn_i.hit | match;
  assign dn_o.f_ref  = dn_i.f_ref | (sel ? ref_q : '0);
  assign dn_o.f_mode = dn_i.f_mode | (sel ? mode_q : '0);
  assign up_o        = up_i | sel;

  assign entry_o.key     = KEY_W'(key_q);
  assign entry_o.obj_ref = ref_q;
  assign entry_o.mode    = mode_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_en && tail_i) begin
      key_q  <= cmd_i.key[KW-1:0];
      ref_q  <= cmd_i.obj_ref;
      mode_q <= cmd_i.new_mode;
    end else if (shift) begin
      key_q  <= above_i.key[KW-1:0];
      ref_q  <= above_i.obj_ref;
      mode_q <= above_i.mode;
    end else if (cmd_i.upd_en && sel && (mode_q == cmd_i.exp_mode)) begin
      mode_q <= cmd_i.new_mode;
    end
  end

endmodule
